FILE: hdl/spq_pkg.sv
// Package for the pressure qualifier: register indexes, reset values,
// scaling constants, status codes and the raw-to-pressure scaling function.
// No dependencies.
package spq_pkg;

   // configuration register indexes
   localparam logic [2:0] REG_TIMEOUT_LIMIT     = 3'd0;
   localparam logic [2:0] REG_LOW_THRESHOLD     = 3'd1;
   localparam logic [2:0] REG_LOW_COUNT_LIMIT   = 3'd2;
   localparam logic [2:0] REG_SPIKE_THRESHOLD   = 3'd3;
   localparam logic [2:0] REG_SPIKE_COUNT_LIMIT = 3'd4;

   // configuration reset values
   localparam logic [15:0] TIMEOUT_LIMIT_RST     = 16'd10000;
   localparam logic [15:0] LOW_THRESHOLD_RST     = 16'd80;
   localparam logic [15:0] LOW_COUNT_LIMIT_RST   = 16'd1000;
   localparam logic [15:0] SPIKE_THRESHOLD_RST   = 16'd30;
   localparam logic [15:0] SPIKE_COUNT_LIMIT_RST = 16'd1000;

   // status codes
   localparam logic [1:0] STATUS_NORMAL    = 2'd0;
   localparam logic [1:0] STATUS_DISTURBED = 2'd1;
   localparam logic [1:0] STATUS_LOW       = 2'd2;

   // raw value conditioning
   localparam logic [11:0] SNAP_LOW   = 12'd370;
   localparam logic [11:0] SNAP_TO    = 12'd410;
   localparam logic [11:0] RAW_CLAMP  = 12'd3686;
   localparam logic [15:0] FULL_SCALE = 16'd45000;

   // (raw - 410) * 45000 / 3276 == (raw - 410) * 11250 / 819, done as a
   // multiply by ceil(2^22 * 11250 / 819) and a shift; exact for inputs <= 3276
   localparam int          RECIP_SHIFT = 22;
   localparam logic [25:0] RECIP       = 26'd57614066;

   localparam logic [1:0] TICK_SEEN_MAX = 2'd2;
   localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

   function automatic logic [15:0] scale_raw(input logic [11:0] raw);
      logic [11:0] v;
      logic [11:0] d;
      logic [37:0] prod;
      begin
         v = raw;
         if (raw > SNAP_LOW && raw < SNAP_TO) begin
            v = SNAP_TO;
         end else if (raw > RAW_CLAMP) begin
            v = RAW_CLAMP;
         end
         d    = v - SNAP_TO;
         prod = {26'd0, d} * {12'd0, RECIP};
         if (v <= SNAP_TO) begin
            scale_raw = 16'd0;
         end else begin
            scale_raw = prod[RECIP_SHIFT +: 16];
         end
      end
   endfunction

endpackage

FILE: hdl/sent_pressure_qualifier_unit.sv
// Pressure qualifier top level: input stage with scaling, state update and
// result register. Depends on spq_pkg.
//
// Usage:
//   One request per poll tick on the req_ channel: req_tuser carries the
//   frame-valid bit, req_tdata the received fast-channel word (bits 23..12
//   are the raw value). Each request yields exactly one result on rsp_:
//   status code, no-communication flag and the latest scaled pressure.
//   The raw value is scaled into the input register; the qualifier state and
//   the result register are updated together once the result register is
//   free. One request is taken every cycle while the receiver takes results.
//   When the receiver stalls, the result register holds and the input stage
//   takes one more request only if its register is empty; after that
//   req_tready stays low until the result is taken.
//   Reset (synchronous, active high) clears the qualifier state and loads
//   the default register values. Configuration writes on csr_ take effect at
//   the next edge and must be made while no request is in flight.
module sent_pressure_qualifier_unit
   import spq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] frame_word
   input  logic        req_tuser,   // [0] frame_valid
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [1:0] status, [2] no_comm, [18:3] pressure, zero fill
   // configuration port
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   // configuration
   logic [15:0] timeout_limit_ff;
   logic [15:0] low_threshold_ff;
   logic [15:0] low_count_limit_ff;
   logic [15:0] spike_threshold_ff;
   logic [15:0] spike_count_limit_ff;

   // input stage
   logic        s1_valid_ff;
   logic        s1_frame_ff;
   logic [15:0] s1_press_ff;

   // qualifier state
   logic [15:0] prev_ff,     prev_in;
   logic [15:0] last_ff,     last_in;
   logic [15:0] latest_ff,   latest_in;
   logic [15:0] sil_cnt_ff,  sil_cnt_in;
   logic        sil_flag_ff, sil_flag_in;
   logic [15:0] low_run_ff,  low_run_in;
   logic [15:0] spike_run_ff, spike_run_in;
   logic [1:0]  status_ff,   status_in;
   logic [1:0]  tick_ff,     tick_in;

   // result register
   logic        rsp_valid_ff;
   logic [23:0] rsp_data_ff;

   logic        out_free;
   logic        commit;
   logic        req_take;
   logic [15:0] last_new;
   logic [15:0] prev_new;
   logic [15:0] diff;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign commit     = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_limit_ff     <= TIMEOUT_LIMIT_RST;
         low_threshold_ff     <= LOW_THRESHOLD_RST;
         low_count_limit_ff   <= LOW_COUNT_LIMIT_RST;
         spike_threshold_ff   <= SPIKE_THRESHOLD_RST;
         spike_count_limit_ff <= SPIKE_COUNT_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_TIMEOUT_LIMIT:     timeout_limit_ff     <= csr_wdata;
            REG_LOW_THRESHOLD:     low_threshold_ff     <= csr_wdata;
            REG_LOW_COUNT_LIMIT:   low_count_limit_ff   <= csr_wdata;
            REG_SPIKE_THRESHOLD:   spike_threshold_ff   <= csr_wdata;
            REG_SPIKE_COUNT_LIMIT: spike_count_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input stage: scale on the way in
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
      if (req_take) begin
         s1_frame_ff <= req_tuser;
         s1_press_ff <= scale_raw(req_tdata[23:12]);
      end
   end

   assign last_new = s1_frame_ff ? s1_press_ff : last_ff;
   assign prev_new = s1_frame_ff ? last_ff : prev_ff;
   assign diff     = (last_new >= prev_new) ? (last_new - prev_new) : (prev_new - last_new);

   always_comb begin
      prev_in      = prev_new;
      last_in      = last_new;
      latest_in    = s1_frame_ff ? s1_press_ff : latest_ff;
      tick_in      = (tick_ff < TICK_SEEN_MAX) ? tick_ff + 2'd1 : tick_ff;
      sil_cnt_in   = sil_cnt_ff;
      sil_flag_in  = sil_flag_ff;
      low_run_in   = low_run_ff;
      spike_run_in = spike_run_ff;
      status_in    = status_ff;

      // silence watch
      if (s1_frame_ff) begin
         sil_flag_in = 1'b0;
         sil_cnt_in  = 16'd0;
      end else if (sil_cnt_ff >= timeout_limit_ff) begin
         sil_flag_in = 1'b1;
         sil_cnt_in  = 16'd0;
      end else begin
         sil_cnt_in = sil_cnt_ff + 16'd1;
      end

      if (!sil_flag_in) begin
         // low check
         if (last_new <= low_threshold_ff) begin
            if (low_run_ff > low_count_limit_ff) begin
               status_in = STATUS_LOW;
            end else if (low_run_ff != COUNT_MAX) begin
               low_run_in = low_run_ff + 16'd1;
            end
         end else begin
            low_run_in = 16'd0;
            if (status_ff == STATUS_LOW) begin
               status_in = STATUS_NORMAL;
            end
         end

         // spike check, from the second tick on
         if (tick_in >= TICK_SEEN_MAX) begin
            if (diff > spike_threshold_ff) begin
               if (status_in == STATUS_NORMAL) begin
                  last_in = prev_new;
                  if (spike_run_ff != COUNT_MAX) begin
                     spike_run_in = spike_run_ff + 16'd1;
                  end
               end
            end else begin
               spike_run_in = 16'd0;
               status_in    = STATUS_NORMAL;
            end
            if (spike_run_in >= spike_count_limit_ff) begin
               status_in = STATUS_DISTURBED;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         last_ff      <= '0;
         latest_ff    <= '0;
         sil_cnt_ff   <= '0;
         sil_flag_ff  <= 1'b0;
         low_run_ff   <= '0;
         spike_run_ff <= '0;
         status_ff    <= STATUS_NORMAL;
         tick_ff      <= '0;
      end else if (commit) begin
         prev_ff      <= prev_in;
         last_ff      <= last_in;
         latest_ff    <= latest_in;
         sil_cnt_ff   <= sil_cnt_in;
         sil_flag_ff  <= sil_flag_in;
         low_run_ff   <= low_run_in;
         spike_run_ff <= spike_run_in;
         status_ff    <= status_in;
         tick_ff      <= tick_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (commit) begin
         rsp_data_ff <= {5'd0, latest_in, sil_flag_in, status_in};
      end
   end

`ifndef SYNTHESIS
   a_commit_loads: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("result register not loaded after commit");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff[1:0] <= STATUS_LOW)
      else $error("undefined status code");

   a_pressure_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff[18:3] <= FULL_SCALE)
      else $error("pressure above full scale");

   a_tick_sat: assert property (@(posedge clock) disable iff (reset)
      tick_ff <= TICK_SEEN_MAX)
      else $error("tick counter past saturation");
`endif

endmodule
